FILE: rtl/core/dual_stack_shared_memory_core_defines.svh
// ----------------------------------------------------------------------------
// Dual stack shared memory core - assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_SHARED_MEMORY_CORE_DEFINES_SVH
`define DUAL_STACK_SHARED_MEMORY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define DSSM_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define DSSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DSSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DSSM_ASSERT(label, clk, rst, expr)
`define DSSM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DSSM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/dssm_pkg.sv
// ----------------------------------------------------------------------------
// Dual stack shared memory package
// Sizes, operation codes and status codes shared by the core.
// ----------------------------------------------------------------------------
package dssm_pkg;

   localparam int STORE_DEPTH = 128;
   localparam int WORD_W      = 32;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int SUM_W       = CNT_W + 1;

   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;

   localparam op_type OP_PUSH = 2'd0;
   localparam op_type OP_POP  = 2'd1;
   localparam op_type OP_PEEK = 2'd2;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_OVERFLOW = 2'd1;
   localparam status_type ST_EMPTY    = 2'd2;

   localparam logic SEL_A = 1'b0;

endpackage

FILE: rtl/core/dssm_ram.sv
// ----------------------------------------------------------------------------
// Dual stack shared memory RAM
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dssm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

FILE: rtl/core/dual_stack_shared_memory_core.sv
// Timing: push, empty and unused requests are answered from the response
// register; pop and peek first read the RAM in S_READ, then fill it.
// Throughput: one push per cycle while responses are taken; no request is
// taken while a pop/peek reads the single registered read port of the RAM.
// Reset: synchronous; both stacks empty, RAM contents left as they are.
// ----------------------------------------------------------------------------
// Dual stack shared memory core
// Two LIFO stacks in one RAM: stack A grows up from entry 0, stack B grows
// down from the last entry. Push, pop and peek with overflow/empty status.
// ----------------------------------------------------------------------------
`include "dual_stack_shared_memory_core_defines.svh"

module dual_stack_shared_memory_core
   import dssm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [2:0]  req_tuser,   // [1:0] operation, [2] which_stack
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] read_value
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_a_ff, count_a_in;
   logic [CNT_W-1:0]   count_b_ff, count_b_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               req_accept;
   op_type             req_op;
   logic               req_sel;
   logic               store_full;
   logic               stack_empty;
   logic               push_ok;
   logic [ADDR_W-1:0]  push_idx;
   logic [ADDR_W-1:0]  top_idx;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [WORD_W-1:0]  ram_rdata;

   assign req_op      = req_tuser[1:0];
   assign req_sel     = req_tuser[2];
   assign req_tready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept  = req_tvalid && req_tready;
   assign store_full  = ({1'b0, count_a_ff} + {1'b0, count_b_ff}) >= SUM_W'(STORE_DEPTH);
   assign stack_empty = (req_sel == SEL_A) ? (count_a_ff == '0) : (count_b_ff == '0);
   assign push_ok     = req_accept && (req_op == OP_PUSH) && !store_full;
   assign push_idx    = (req_sel == SEL_A)
                      ? count_a_ff[ADDR_W-1:0]
                      : ADDR_W'(STORE_DEPTH - 1) - count_b_ff[ADDR_W-1:0];
   assign top_idx     = (req_sel == SEL_A)
                      ? count_a_ff[ADDR_W-1:0] - 1'b1
                      : ADDR_W'(STORE_DEPTH) - count_b_ff[ADDR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_addr      = (req_op == OP_PUSH) ? push_idx : top_idx;

      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = ST_OK;
         case (req_op)
            OP_PUSH: begin
               if (store_full) begin
                  rsp_status_in = ST_OVERFLOW;
               end else begin
                  ram_we = 1'b1;
                  if (req_sel == SEL_A) begin
                     count_a_in = count_a_ff + 1'b1;
                  end else begin
                     count_b_in = count_b_ff + 1'b1;
                  end
               end
            end
            OP_POP, OP_PEEK: begin
               if (stack_empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_READ;
                  if (req_op == OP_POP) begin
                     if (req_sel == SEL_A) begin
                        count_a_in = count_a_ff - 1'b1;
                     end else begin
                        count_b_in = count_b_ff - 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (state_ff == S_READ) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = ram_rdata;
         rsp_status_in = ST_OK;
         state_in      = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   dssm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_tdata),
      .rdata (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   `DSSM_ASSERT(a_count_bound, clock, reset, ({1'b0, count_a_ff} + {1'b0, count_b_ff}) <= SUM_W'(STORE_DEPTH))
   `DSSM_ASSERT_IMPLY(a_read_slot_free, clock, reset, state_ff == S_READ, !rsp_valid_ff && !req_tready)
   `DSSM_ASSERT_NEXT(a_read_answers, clock, reset, state_ff == S_READ, rsp_tvalid && (rsp_tuser == ST_OK))
   `DSSM_ASSERT_NEXT(a_push_a_count, clock, reset, push_ok && (req_sel == SEL_A), count_a_ff == $past(count_a_ff) + 1'b1)

endmodule

FILE: verif/tb_dual_stack_shared_memory_core.sv
// ----------------------------------------------------------------------------
// Dual stack shared memory core testbench
// Drives push, pop, peek and unused requests on both stacks: empty stacks,
// word extremes, the store filled from one side and from both sides, and
// random mixes with random gaps on both handshakes. Every response is
// compared with a predictor that keeps its own copy of both stacks.
// ----------------------------------------------------------------------------
module tb_dual_stack_shared_memory_core
   import dssm_pkg::*;
;

   localparam op_type OP_UNUSED = 2'd3;
   localparam logic   SEL_B     = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] read_value;
      status_type        status;
   } stack_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] push_value
   logic [2:0]  req_tuser;   // [1:0] operation, [2] which_stack
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] read_value
   logic [1:0]  rsp_tuser;   // [1:0] status

   logic [WORD_W-1:0] stack_words [STORE_DEPTH];
   int                depth_a = 0;
   int                depth_b = 0;
   stack_result_type  expected_results [$];
   int                error_count = 0;
   bit                idle_on = 1'b1;

   dual_stack_shared_memory_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Applies one accepted request to the stack copy and queues its response.
   function automatic void predict_stack_op(op_type op, logic sel, logic [31:0] value);
      stack_result_type r;
      int               depth;
      int               idx;
      r.read_value = '0;
      r.status     = ST_OK;
      depth        = (sel == SEL_A) ? depth_a : depth_b;
      if (op == OP_PUSH) begin
         if (depth_a + depth_b >= STORE_DEPTH) begin
            r.status = ST_OVERFLOW;
         end else if (sel == SEL_A) begin
            stack_words[depth_a] = value;
            depth_a++;
         end else begin
            depth_b++;
            stack_words[STORE_DEPTH - depth_b] = value;
         end
      end else if (op inside {OP_POP, OP_PEEK}) begin
         if (depth == 0) begin
            r.status = ST_EMPTY;
         end else begin
            idx          = (sel == SEL_A) ? depth_a - 1 : STORE_DEPTH - depth_b;
            r.read_value = stack_words[idx];
            if (op == OP_POP) begin
               if (sel == SEL_A) depth_a--;
               else depth_b--;
            end
         end
      end
      expected_results.push_back(r);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(op_type op, logic sel, logic [31:0] value);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= {sel, op};
      do @(posedge clock); while (!req_tready);
      predict_stack_op(op, sel, value);
   endtask

   task automatic run_random_ops(int n, int push_pct, int pop_pct);
      int     pick;
      op_type op;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < push_pct) op = OP_PUSH;
         else if (pick < push_pct + pop_pct) op = OP_POP;
         else if (pick < 97) op = OP_PEEK;
         else op = OP_UNUSED;
         send_request(op, 1'($urandom_range(0, 1)), pick_value());
      end
   endtask

   task automatic test_empty_and_unused();
      send_request(OP_POP,    SEL_A, 32'h1234_5678);
      send_request(OP_POP,    SEL_B, 32'hffff_ffff);
      send_request(OP_PEEK,   SEL_A, 32'h0000_0000);
      send_request(OP_PEEK,   SEL_B, 32'h8000_0000);
      send_request(OP_UNUSED, SEL_A, 32'hdead_beef);
      send_request(OP_UNUSED, SEL_B, 32'h0000_0001);
   endtask

   task automatic test_push_pop_extremes();
      send_request(OP_PUSH,   SEL_A, 32'h7fff_ffff);
      send_request(OP_PUSH,   SEL_A, 32'h8000_0000);
      send_request(OP_PUSH,   SEL_B, 32'h0000_0000);
      send_request(OP_PUSH,   SEL_B, 32'hffff_ffff);
      send_request(OP_PUSH,   SEL_B, 32'h5555_5555);
      send_request(OP_PUSH,   SEL_A, 32'haaaa_aaaa);
      send_request(OP_PEEK,   SEL_A, 32'h0);
      send_request(OP_PEEK,   SEL_B, 32'h0);
      send_request(OP_POP,    SEL_A, 32'h0);
      send_request(OP_POP,    SEL_B, 32'h0);
      send_request(OP_POP,    SEL_A, 32'h0);
      send_request(OP_PEEK,   SEL_A, 32'h0);
      send_request(OP_POP,    SEL_B, 32'h0);
      send_request(OP_POP,    SEL_B, 32'h0);
      send_request(OP_POP,    SEL_B, 32'h0);
      send_request(OP_UNUSED, SEL_A, 32'hffff_ffff);
      send_request(OP_POP,    SEL_A, 32'h0);
      send_request(OP_PEEK,   SEL_A, 32'h0);
   endtask

   // Fills the store, tries both stacks while full, then drains it.
   task automatic test_full_store(int pct_b);
      logic sel;
      while (depth_a + depth_b < STORE_DEPTH) begin
         sel = ($urandom_range(0, 99) < pct_b);
         send_request(OP_PUSH, sel, pick_value());
      end
      send_request(OP_PUSH,   SEL_A, pick_value());
      send_request(OP_PUSH,   SEL_B, pick_value());
      send_request(OP_PEEK,   SEL_A, $urandom);
      send_request(OP_PEEK,   SEL_B, $urandom);
      send_request(OP_UNUSED, SEL_A, $urandom);
      while (depth_a + depth_b > 0) begin
         sel = ($urandom_range(0, 99) < pct_b);
         send_request(($urandom_range(0, 7) == 0) ? OP_PEEK : OP_POP, sel, $urandom);
      end
      send_request(OP_POP, SEL_A, $urandom);
      send_request(OP_POP, SEL_B, $urandom);
   endtask

   task automatic test_random_mix();
      run_random_ops(25, 70, 20);
      run_random_ops(25, 20, 60);
      run_random_ops(25, 45, 35);
   endtask

   task automatic test_drain_pause();
      run_random_ops(20, 60, 25);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      run_random_ops(20, 40, 40);
   endtask

   // Back-to-back requests and responses, no gaps on either side.
   task automatic test_back_to_back();
      idle_on = 1'b0;
      run_random_ops(50, 50, 35);
   endtask

   initial begin : rsp_ready_driver
      forever begin
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : response_check
      stack_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response: expected none, actual read_value=%h status=%0d",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_tdata !== exp_r.read_value) begin
               error_count++;
               $display("%0t: read_value mismatch: expected %h, actual %h",
                        $time, exp_r.read_value, rsp_tdata);
            end
            if (rsp_tuser !== exp_r.status) begin
               error_count++;
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, exp_r.status, rsp_tuser);
            end
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_unused();
      test_push_pop_extremes();
      test_full_store(0);
      test_full_store(90);
      test_random_mix();
      test_drain_pause();
      test_back_to_back();

      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/dssm_pkg.sv
rtl/core/dssm_ram.sv
rtl/core/dual_stack_shared_memory_core.sv
verif/tb_dual_stack_shared_memory_core.sv
